[rtl/core/bgp_pkg.sv]
// Shared types and constants for the bitmap glyph placer.
// Input and result item structs, operation and register codes, FSM states.
// No dependencies.
`timescale 1ns / 1ps

package bgp_pkg;

    // Character codes
    localparam logic [7:0] NEWLINE_CODE = 8'h0A;
    localparam logic [7:0] LOWER_A_CODE = 8'h61;
    localparam logic [7:0] LOWER_Z_CODE = 8'h7A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    // Width of the index divider: map indexes stay below 256
    localparam int DIV_W = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // Register reset values
    localparam logic [7:0] GLYPH_WIDTH_RST   = 8'd8;
    localparam logic [7:0] GLYPH_HEIGHT_RST  = 8'd8;
    localparam logic [7:0] SHEET_COLUMNS_RST = 8'd16;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_START = 2'd1,
        OP_CHAR  = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GLYPH_WIDTH   = 3'd0,
        REG_GLYPH_HEIGHT  = 3'd1,
        REG_SPACING_X     = 3'd2,
        REG_SPACING_Y     = 3'd3,
        REG_SHEET_COLUMNS = 3'd4,
        REG_MAP_COUNT     = 3'd5,
        REG_FOLD_UPPER    = 3'd6
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV
    } state_t;

    typedef struct packed {
        logic        [1:0]  operation;
        logic        [7:0]  char_code;
        logic        [5:0]  map_slot;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] dest_x;
        logic signed [15:0] dest_y;
        logic        [15:0] src_x;
        logic        [15:0] src_y;
        logic        [5:0]  glyph_index;
    } result_t;

endpackage

[rtl/core/bgp_map_mem.sv]
// Glyph map storage: one write port, one read port, registered read data.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module bgp_map_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered read data, updated when re is high
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/bgp_div.sv]
// Restoring divider, one quotient bit per cycle, for glyph index by sheet columns.
// Depends on bgp_pkg for DIV_W.
`timescale 1ns / 1ps

module bgp_div
    import bgp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient,
    output logic [DIV_W-1:0] remainder
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic             run_reg,  run_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic [DIV_W-1:0] rem_reg,  rem_next;
    logic [DIV_W-1:0] quo_reg,  quo_next;
    logic [DIV_W-1:0] dsr_reg,  dsr_next;
    logic [DIV_W:0]   shifted;
    logic [DIV_W:0]   diff;
    logic             ge;

    // One restoring step: bring down the next dividend bit
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DIV_W-1]};
        ge        = (shifted >= {1'b0, dsr_reg});
        diff      = shifted - {1'b0, dsr_reg};
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            rem_next = '0;
            quo_next = dividend;
            dsr_next = divisor;
        end
        else if (run_reg)
        begin
            rem_next = ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], ge};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DIV_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

[rtl/core/bitmap_glyph_placer.sv]
// Top level of the bitmap glyph placer: command FSM, cursor registers, config.
// Depends on bgp_pkg, bgp_map_mem and bgp_div.
`timescale 1ns / 1ps

// An item is taken when start is high and busy is low. Load and start items,
// newlines, and characters searched against an empty map (map_count of zero)
// finish in the accept cycle and leave busy low. Any other character scans the
// glyph map memory one entry per cycle, first match wins, and a match then
// runs the index divider and forms the result from its quotient and remainder.
// A result is shown on result for exactly one cycle with result_valid high and
// cannot be held off; the next item may be accepted in that same cycle. Config
// writes are taken at any edge with cfg_we high and must only be made while the
// block is idle. Map entries never loaded read as undefined.
module bitmap_glyph_placer
    import bgp_pkg::*;
#(
    parameter int MAP_SIZE = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  in_item_t              in_item,
    output logic                  result_valid,
    output result_t               result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W = (MAP_SIZE > 1) ? $clog2(MAP_SIZE) : 1;
    localparam int CNT_W = $clog2(MAP_SIZE + 1);

    // Config registers
    logic [7:0] glyph_width_reg;
    logic [7:0] glyph_height_reg;
    logic [7:0] spacing_x_reg;
    logic [7:0] spacing_y_reg;
    logic [7:0] sheet_columns_reg;
    logic [6:0] map_count_reg;
    logic       fold_upper_reg;

    // Control and cursor state
    state_t           state_reg,     state_next;
    logic [CNT_W-1:0] iss_cnt_reg,   iss_cnt_next;
    logic             chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0] chk_idx_reg,   chk_idx_next;
    logic [IDX_W-1:0] found_idx_reg, found_idx_next;
    logic [7:0]       code_reg,      code_next;
    logic [15:0]      cursor_x_reg,  cursor_x_next;
    logic [15:0]      cursor_y_reg,  cursor_y_next;
    logic [15:0]      origin_x_reg,  origin_x_next;
    logic             result_valid_reg, result_valid_next;
    result_t          result_reg,    result_next;

    // Map memory and divider hookup
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;
    logic [7:0]       mem_rdata;
    logic             div_start;
    logic [DIV_W-1:0] div_divisor;
    logic             div_done;
    logic [DIV_W-1:0] div_quo;
    logic [DIV_W-1:0] div_rem;

    // Derived values
    logic [8:0]       slot_ext;
    logic [8:0]       count_ext;
    logic [CNT_W-1:0] limit;
    logic [15:0]      advance;
    logic [15:0]      line_step;
    logic [7:0]       folded_code;
    logic             accept;
    logic [DIV_W-1:0] found_idx_ext;

    bgp_map_mem #(
        .DEPTH (MAP_SIZE),
        .AW    (IDX_W)
    ) u_map (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (in_item.char_code),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    bgp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (DIV_W'(chk_idx_reg)),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Config derived terms
    always_comb
    begin
        slot_ext    = {3'b000, in_item.map_slot};
        count_ext   = {2'b00, map_count_reg};
        limit       = (count_ext > 9'(MAP_SIZE)) ? CNT_W'(MAP_SIZE) : count_ext[CNT_W-1:0];
        advance     = {8'h00, glyph_width_reg} + {{8{spacing_x_reg[7]}}, spacing_x_reg};
        line_step   = {8'h00, glyph_height_reg} + {{8{spacing_y_reg[7]}}, spacing_y_reg};
        div_divisor = (sheet_columns_reg == 8'h00) ? DIV_W'(1) : DIV_W'(sheet_columns_reg);
        accept      = start && (state_reg == ST_IDLE);
        found_idx_ext = DIV_W'(found_idx_reg);
        if (fold_upper_reg && (in_item.char_code >= LOWER_A_CODE)
            && (in_item.char_code <= LOWER_Z_CODE))
        begin
            folded_code = in_item.char_code - CASE_OFFSET;
        end
        else
        begin
            folded_code = in_item.char_code;
        end
    end

    // Next state and outputs
    always_comb
    begin
        state_next        = state_reg;
        iss_cnt_next      = iss_cnt_reg;
        chk_valid_next    = 1'b0;
        chk_idx_next      = chk_idx_reg;
        found_idx_next    = found_idx_reg;
        code_next         = code_reg;
        cursor_x_next     = cursor_x_reg;
        cursor_y_next     = cursor_y_reg;
        origin_x_next     = origin_x_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;
        mem_we            = 1'b0;
        mem_waddr         = slot_ext[IDX_W-1:0];
        mem_re            = 1'b0;
        mem_raddr         = iss_cnt_reg[IDX_W-1:0];
        div_start         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_item.operation)
                        OP_LOAD:
                        begin
                            mem_we = (slot_ext < 9'(MAP_SIZE));
                        end
                        OP_START:
                        begin
                            origin_x_next = in_item.start_x;
                            cursor_x_next = in_item.start_x;
                            cursor_y_next = in_item.start_y;
                        end
                        OP_CHAR:
                        begin
                            if (in_item.char_code == NEWLINE_CODE)
                            begin
                                cursor_x_next = origin_x_reg;
                                cursor_y_next = cursor_y_reg + line_step;
                            end
                            else if (limit == '0)
                            begin
                                // nothing to search: advance like a space
                                cursor_x_next = cursor_x_reg + advance;
                            end
                            else
                            begin
                                code_next    = folded_code;
                                iss_cnt_next = '0;
                                state_next   = ST_SCAN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                // issue one read per cycle while entries remain
                if (iss_cnt_reg < limit)
                begin
                    mem_re         = 1'b1;
                    chk_valid_next = 1'b1;
                    chk_idx_next   = iss_cnt_reg[IDX_W-1:0];
                    iss_cnt_next   = iss_cnt_reg + CNT_W'(1);
                end
                // check the entry read last cycle
                if (chk_valid_reg && (mem_rdata == code_reg))
                begin
                    found_idx_next = chk_idx_reg;
                    div_start      = 1'b1;
                    chk_valid_next = 1'b0;
                    state_next     = ST_DIV;
                end
                else if (chk_valid_reg && ((CNT_W'(chk_idx_reg) + CNT_W'(1)) == limit))
                begin
                    cursor_x_next  = cursor_x_reg + advance;
                    chk_valid_next = 1'b0;
                    state_next     = ST_IDLE;
                end
            end

            ST_DIV:
            begin
                if (div_done)
                begin
                    result_next.dest_x      = cursor_x_reg;
                    result_next.dest_y      = cursor_y_reg;
                    result_next.src_x       = 16'(div_rem) * 16'(glyph_width_reg);
                    result_next.src_y       = 16'(div_quo) * 16'(glyph_height_reg);
                    result_next.glyph_index = found_idx_ext[5:0];
                    result_valid_next       = 1'b1;
                    cursor_x_next           = cursor_x_reg + advance;
                    state_next              = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and cursor registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            iss_cnt_reg      <= '0;
            chk_valid_reg    <= 1'b0;
            cursor_x_reg     <= '0;
            cursor_y_reg     <= '0;
            origin_x_reg     <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            iss_cnt_reg      <= iss_cnt_next;
            chk_valid_reg    <= chk_valid_next;
            cursor_x_reg     <= cursor_x_next;
            cursor_y_reg     <= cursor_y_next;
            origin_x_reg     <= origin_x_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        chk_idx_reg   <= chk_idx_next;
        found_idx_reg <= found_idx_next;
        code_reg      <= code_next;
        result_reg    <= result_next;
    end

    // Config write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glyph_width_reg   <= GLYPH_WIDTH_RST;
            glyph_height_reg  <= GLYPH_HEIGHT_RST;
            spacing_x_reg     <= '0;
            spacing_y_reg     <= '0;
            sheet_columns_reg <= SHEET_COLUMNS_RST;
            map_count_reg     <= '0;
            fold_upper_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GLYPH_WIDTH:   glyph_width_reg   <= cfg_data;
                REG_GLYPH_HEIGHT:  glyph_height_reg  <= cfg_data;
                REG_SPACING_X:     spacing_x_reg     <= cfg_data;
                REG_SPACING_Y:     spacing_y_reg     <= cfg_data;
                REG_SHEET_COLUMNS: sheet_columns_reg <= cfg_data;
                REG_MAP_COUNT:     map_count_reg     <= cfg_data[6:0];
                REG_FOLD_UPPER:    fold_upper_reg    <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
